/* rtl/ctr_pkg.sv */
// package for the can transport reassembler: result kinds, frame types, constants
// no dependencies
`timescale 1ns / 1ps

package ctr_pkg;

   localparam int unsigned DefaultSlots   = 8;
   localparam int unsigned ResultLimit    = 8;
   localparam logic [31:0] TimeoutReset   = 32'd1000000;

   typedef enum logic [2:0] {
      KIND_SINGLE  = 3'd0,
      KIND_FIRST   = 3'd1,
      KIND_MIDDLE  = 3'd2,
      KIND_FINAL   = 3'd3,
      KIND_SEQERR  = 3'd4,
      KIND_TIMEOUT = 3'd5,
      KIND_FULL    = 3'd6
   } kind_type;

   localparam logic [3:0] PCI_SINGLE      = 4'd0;
   localparam logic [3:0] PCI_FIRST       = 4'd1;
   localparam logic [3:0] PCI_CONSECUTIVE = 4'd2;

   localparam logic OP_FRAME = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam logic [1:0] REG_IDLE_TIMEOUT = 2'd0;

   // one result item as it leaves the block
   typedef struct packed {
      logic [28:0] message_id;
      kind_type    kind;
      logic [47:0] start_time;
      logic [11:0] total_length;
      logic [2:0]  byte_count;
      logic [55:0] payload_bytes;
      logic        last;
   } result_type;

   // bytes pos..pos+cnt-1 of the frame data, zero above
   function automatic logic [55:0] take_bytes(input logic [63:0] data, input logic [1:0] pos,
                                              input logic [2:0] cnt);
      logic [63:0] v;
      logic [55:0] m;
      begin
         v = data >> {pos, 3'b000};
         m = 56'((64'd1 << {cnt, 3'b000}) - 64'd1);
         take_bytes = v[55:0] & m;
      end
   endfunction

endpackage

/* rtl/ctr_result_reg.sv */
// output register for result items, valid/ready handshake
// depends on ctr_pkg
`timescale 1ns / 1ps

module ctr_result_reg
   import ctr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   output logic       full,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_data
);

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign full      = valid_ff;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

/* rtl/can_transport_reassembler.sv */
// can transport reassembler top level: session table, slot scan sequencer
// depends on ctr_pkg, ctr_result_reg
`timescale 1ns / 1ps

// channel   direction  handshake             payload
// req_      in         req_valid/req_ready   opcode, frame_id, frame_length, frame_bytes, time_us
// rsp_      out        rsp_valid/rsp_ready   message_id .. last
// csr_      in/out     apb psel/penable      idle_timeout_us at address 0
// a frame walks the slot table one slot per cycle (id match, free slot search), then acts;
// a tick scans with the idle compare; no new item is accepted until the result register empties
// a tick holds each timeout result until the scan finds the next expiring slot or ends
// reset is synchronous; all slots become free, no clearing pass
module can_transport_reassembler
   import ctr_pkg::*;
#(
   parameter int unsigned SESSION_SLOTS = DefaultSlots
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [28:0] req_frame_id,
   input  logic [3:0]  req_frame_length,
   input  logic [63:0] req_frame_bytes,
   input  logic [47:0] req_time_us,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [28:0] rsp_message_id,
   output logic [2:0]  rsp_kind,
   output logic [47:0] rsp_start_time,
   output logic [11:0] rsp_total_length,
   output logic [2:0]  rsp_byte_count,
   output logic [55:0] rsp_payload_bytes,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int unsigned SW = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
   localparam int unsigned CW = $clog2(SESSION_SLOTS + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_ACT, ST_EMIT, ST_WAIT
   } state_type;

   state_type state_ff;
   logic [31:0] timeout_ff;

   // session table
   logic [SESSION_SLOTS-1:0] valid_ff;
   logic [28:0] id_ff    [SESSION_SLOTS];
   logic [11:0] total_ff [SESSION_SLOTS];
   logic [11:0] recv_ff  [SESSION_SLOTS];
   logic [3:0]  seq_ff   [SESSION_SLOTS];
   logic [47:0] start_ff [SESSION_SLOTS];
   logic [47:0] lastt_ff [SESSION_SLOTS];

   // captured item
   logic        op_ff;
   logic [28:0] fid_ff;
   logic [3:0]  dlc_ff;
   logic [63:0] data_ff;
   logic [47:0] now_ff;

   logic [CW-1:0] idx_ff;
   logic          hit_ff, free_ff;
   logic [SW-1:0] hit_slot_ff, free_slot_ff;
   result_type    res_ff;

   logic          out_full, out_load;
   result_type    out_data;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == {REG_IDLE_TIMEOUT}) ? timeout_ff : 32'd0;
   assign req_ready  = (state_ff == ST_IDLE);

   // shared per-slot compare unit
   logic [SW-1:0] cur;
   logic [47:0]   idle;
   logic          expired, match;
   assign cur     = idx_ff[SW-1:0];
   assign idle    = now_ff - lastt_ff[cur];
   assign expired = valid_ff[cur] && (idle > {16'd0, timeout_ff});
   assign match   = valid_ff[cur] && (id_ff[cur] == fid_ff);

   // frame decode
   logic [3:0]  dlc8;
   logic [7:0]  b0;
   logic [11:0] ff_total;
   logic [2:0]  cf_chunk_raw;
   logic [11:0] remaining;
   logic [2:0]  chunk;
   logic [11:0] recv_new;
   always_comb begin
      dlc8         = (dlc_ff > 4'd8) ? 4'd8 : dlc_ff;
      b0           = data_ff[7:0];
      ff_total     = {b0[3:0], data_ff[15:8]};
      cf_chunk_raw = 3'(dlc8 - 4'd1);
      remaining    = (total_ff[hit_slot_ff] > recv_ff[hit_slot_ff])
                     ? total_ff[hit_slot_ff] - recv_ff[hit_slot_ff] : 12'd0;
      chunk        = ({9'd0, cf_chunk_raw} > remaining) ? remaining[2:0] : cf_chunk_raw;
      recv_new     = recv_ff[hit_slot_ff] + {9'd0, chunk};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         timeout_ff <= TimeoutReset;
         valid_ff   <= '0;
         out_load   <= 1'b0;
      end else begin
         out_load <= 1'b0;
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr == {REG_IDLE_TIMEOUT}) begin
            timeout_ff <= csr_pwdata;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  op_ff   <= req_opcode;
                  fid_ff  <= req_frame_id;
                  dlc_ff  <= req_frame_length;
                  data_ff <= req_frame_bytes;
                  now_ff  <= req_time_us;
                  idx_ff  <= '0;
                  hit_ff  <= 1'b0;
                  free_ff <= 1'b0;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (op_ff == OP_TICK) begin
                  if (expired) begin
                     res_ff <= '{message_id: id_ff[cur], kind: KIND_TIMEOUT,
                                 start_time: start_ff[cur], total_length: total_ff[cur],
                                 byte_count: 3'd0, payload_bytes: 56'd0, last: 1'b0};
                     valid_ff[cur] <= 1'b0;
                     state_ff      <= ST_EMIT;
                  end else if (idx_ff == CW'(SESSION_SLOTS - 1)) begin
                     state_ff <= ST_WAIT;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end else begin
                  if (match && !hit_ff) begin
                     hit_ff      <= 1'b1;
                     hit_slot_ff <= cur;
                  end
                  if (!valid_ff[cur] && !free_ff) begin
                     free_ff      <= 1'b1;
                     free_slot_ff <= cur;
                  end
                  if (idx_ff == CW'(SESSION_SLOTS - 1)) begin
                     state_ff <= ST_ACT;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
            end
            ST_EMIT: begin
               // tick: wait for the output register, then scan on or release the last result
               if (!out_full && !out_load) begin
                  priority if (idx_ff == CW'(SESSION_SLOTS - 1)) begin
                     res_ff.last <= 1'b1;
                     out_load <= 1'b1;
                     state_ff <= ST_WAIT;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= ST_ACT;
                  end
               end
            end
            ST_ACT: begin
               if (op_ff == OP_TICK) begin
                  // look ahead for another expiring slot before releasing the held result
                  if (expired) begin
                     out_load <= 1'b1;
                     state_ff <= ST_SCAN;
                  end else if (idx_ff == CW'(SESSION_SLOTS - 1)) begin
                     res_ff.last <= 1'b1;
                     out_load <= 1'b1;
                     state_ff <= ST_WAIT;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end else begin
                  state_ff <= ST_WAIT;
                  if (dlc8 != 4'd0) begin
                     unique case (b0[7:4])
                        PCI_SINGLE: begin
                           if (b0[3:0] != 4'd0 && b0[3:0] <= 4'd7 && b0[3:0] <= dlc8 - 4'd1) begin
                              if (hit_ff) valid_ff[hit_slot_ff] <= 1'b0;
                              res_ff <= '{message_id: fid_ff, kind: KIND_SINGLE,
                                          start_time: now_ff, total_length: {8'd0, b0[3:0]},
                                          byte_count: b0[2:0],
                                          payload_bytes: take_bytes(data_ff, 2'd1, b0[2:0]),
                                          last: 1'b1};
                              out_load <= 1'b1;
                           end
                        end
                        PCI_FIRST: begin
                           if (dlc8 >= 4'd3 && ff_total >= 12'd8) begin
                              if (hit_ff || free_ff) begin
                                 valid_ff[hit_ff ? hit_slot_ff : free_slot_ff] <= 1'b1;
                                 id_ff[hit_ff ? hit_slot_ff : free_slot_ff]    <= fid_ff;
                                 total_ff[hit_ff ? hit_slot_ff : free_slot_ff] <= ff_total;
                                 recv_ff[hit_ff ? hit_slot_ff : free_slot_ff]  <=
                                    {8'd0, dlc8 - 4'd2};
                                 seq_ff[hit_ff ? hit_slot_ff : free_slot_ff]   <= 4'd1;
                                 start_ff[hit_ff ? hit_slot_ff : free_slot_ff] <= now_ff;
                                 lastt_ff[hit_ff ? hit_slot_ff : free_slot_ff] <= now_ff;
                                 res_ff <= '{message_id: fid_ff, kind: KIND_FIRST,
                                             start_time: now_ff, total_length: ff_total,
                                             byte_count: 3'(dlc8 - 4'd2),
                                             payload_bytes: take_bytes(data_ff, 2'd2,
                                                                       3'(dlc8 - 4'd2)),
                                             last: 1'b1};
                              end else begin
                                 res_ff <= '{message_id: fid_ff, kind: KIND_FULL,
                                             start_time: now_ff, total_length: ff_total,
                                             byte_count: 3'd0, payload_bytes: 56'd0,
                                             last: 1'b1};
                              end
                              out_load <= 1'b1;
                           end
                        end
                        PCI_CONSECUTIVE: begin
                           if (hit_ff) begin
                              out_load <= 1'b1;
                              if (b0[3:0] != seq_ff[hit_slot_ff]) begin
                                 valid_ff[hit_slot_ff] <= 1'b0;
                                 res_ff <= '{message_id: fid_ff, kind: KIND_SEQERR,
                                             start_time: start_ff[hit_slot_ff],
                                             total_length: total_ff[hit_slot_ff],
                                             byte_count: 3'd0, payload_bytes: 56'd0,
                                             last: 1'b1};
                              end else begin
                                 lastt_ff[hit_slot_ff] <= now_ff;
                                 seq_ff[hit_slot_ff] <= (seq_ff[hit_slot_ff] == 4'd15)
                                    ? 4'd1 : seq_ff[hit_slot_ff] + 4'd1;
                                 recv_ff[hit_slot_ff] <= recv_new;
                                 if (recv_new >= total_ff[hit_slot_ff]) begin
                                    valid_ff[hit_slot_ff] <= 1'b0;
                                 end
                                 res_ff <= '{message_id: fid_ff,
                                             kind: (recv_new >= total_ff[hit_slot_ff])
                                                   ? KIND_FINAL : KIND_MIDDLE,
                                             start_time: start_ff[hit_slot_ff],
                                             total_length: total_ff[hit_slot_ff],
                                             byte_count: chunk,
                                             payload_bytes: take_bytes(data_ff, 2'd1, chunk),
                                             last: 1'b1};
                              end
                           end
                        end
                        default: begin
                        end
                     endcase
                  end
               end
            end
            ST_WAIT: begin
               // hold until the last result has left the output register
               if (!out_load && !out_full) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // out_load pulses the held result into the output register
   assign out_data = res_ff;

   result_type rsp_data;
   ctr_result_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .load_data (out_data),
      .full      (out_full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_message_id    = rsp_data.message_id;
   assign rsp_kind          = rsp_data.kind;
   assign rsp_start_time    = rsp_data.start_time;
   assign rsp_total_length  = rsp_data.total_length;
   assign rsp_byte_count    = rsp_data.byte_count;
   assign rsp_payload_bytes = rsp_data.payload_bytes;
   assign rsp_last          = rsp_data.last;

endmodule

/* rtl/ctr_checker.sv */
// port-level checks for the can transport reassembler, bound to the top level
// depends on ctr_pkg
`timescale 1ns / 1ps

module ctr_checker
   import ctr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_kind,
   input logic [2:0]  rsp_byte_count,
   input logic [55:0] rsp_payload_bytes,
   input logic        rsp_last,
   input logic        csr_pready
);

   a_ready_drops: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted another item at once");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind))
      else $error("stalled result changed");

   a_status_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_SEQERR || rsp_kind == KIND_TIMEOUT ||
                    rsp_kind == KIND_FULL) |-> rsp_byte_count == 3'd0 &&
                    rsp_payload_bytes == 56'd0)
      else $error("status result carries bytes");

   a_frame_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_TIMEOUT |-> rsp_last)
      else $error("frame result not marked last");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");

endmodule

bind can_transport_reassembler ctr_checker u_ctr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_kind          (rsp_kind),
   .rsp_byte_count    (rsp_byte_count),
   .rsp_payload_bytes (rsp_payload_bytes),
   .rsp_last          (rsp_last),
   .csr_pready        (csr_pready)
);
